@@ rtl/lra_pkg.sv @@
`default_nettype none

package lra_pkg;

    localparam int MAX_ROWS_DEF = 16;

    localparam int FILL_W    = 20;
    localparam int ITEM_W    = 12;
    localparam int GAP_W     = 10;
    localparam int CNT_W     = 5;
    localparam int ROW_OUT_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_SIZE  = 2'd1;

    localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};

    typedef struct packed {
        logic [ITEM_W-1:0] width;
        logic              last;
    } q_item_t;

    typedef struct packed {
        logic             reload;
        logic [GAP_W-1:0] gap;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/least_loaded_row_assigner.sv @@
`default_nettype none

// Greedy least-loaded row balancer. Each request carries an item width and a
// last-of-set flag; the block adds width plus gap to the least-filled row in
// use (lowest index on a tie, saturating at 2^20-1) and returns that row, the
// widest row so far and the set-done flag. The rows in use are row_count clamped
// to 1..MAX_ROWS. The back end picks up the request in S_IDLE, reads the row
// store one entry per cycle through its single read port in S_SCAN, finishes
// the last compare in S_WAIT and does the update in S_UPD, where it waits while
// the result register is full and not draining. A two-entry request queue and a
// result register let input and output stall apart.
// Writing either register reloads all rows to gap_size; rows reload likewise
// after a last-of-set request. No clearing pass runs after reset.

module least_loaded_row_assigner
    import lra_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [ITEM_W-1:0]    item_width,
    input  wire logic                 final_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ROW_OUT_W-1:0]      chosen_row,
    output logic [FILL_W-1:0]         widest_row,
    output logic                      set_done
);

    localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic             q_valid;
    q_item_t          q_item;
    logic             q_pop;
    cfg_t             cfg;
    logic [IDX_W-1:0] last_idx;

    lra_front #(
        .MAX_ROWS (MAX_ROWS),
        .IDX_W    (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_width (item_width),
        .final_item (final_item),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .cfg        (cfg),
        .last_idx   (last_idx)
    );

    lra_back #(
        .MAX_ROWS (MAX_ROWS),
        .IDX_W    (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .cfg        (cfg),
        .last_idx   (last_idx),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .chosen_row (chosen_row),
        .widest_row (widest_row),
        .set_done   (set_done)
    );

endmodule

`default_nettype wire

@@ rtl/lra_front.sv @@
`default_nettype none

module lra_front
    import lra_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [ITEM_W-1:0]    item_width,
    input  wire logic                 final_item,
    output logic                      q_valid,
    output q_item_t                   q_item,
    input  wire logic                 q_pop,
    output cfg_t                      cfg,
    output logic [IDX_W-1:0]          last_idx
);

    localparam int NW = ($clog2(MAX_ROWS + 1) > CNT_W) ? $clog2(MAX_ROWS + 1) : CNT_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_ROWS);

    logic [CNT_W-1:0] row_count_reg;
    logic [GAP_W-1:0] gap_reg;
    logic             reload_reg;

    logic    [NW-1:0] n_ext;
    logic    [NW-1:0] n_use;
    logic    [NW-1:0] n_last;

    q_item_t          q_mem_reg [2];
    logic             head_reg;
    logic             tail_reg;
    logic       [1:0] cnt_reg;
    logic             push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(1);
            gap_reg       <= '0;
            reload_reg    <= 1'b0;
        end
        else
        begin
            reload_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT:
                    begin
                        row_count_reg <= cfg_data[CNT_W-1:0];
                        reload_reg    <= 1'b1;
                    end
                    REG_GAP_SIZE:
                    begin
                        gap_reg    <= cfg_data[GAP_W-1:0];
                        reload_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // clamp the row count into 1..MAX_ROWS
    always_comb
    begin
        n_ext = NW'(row_count_reg);
        if (n_ext == '0)
            n_use = NW'(1);
        else if (n_ext > MAX_N)
            n_use = MAX_N;
        else
            n_use = n_ext;
        n_last = n_use - NW'(1);
    end

    assign last_idx   = n_last[IDX_W-1:0];
    assign cfg.reload = reload_reg;
    assign cfg.gap    = gap_reg;

    // two-entry request queue
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[tail_reg].width <= item_width;
            q_mem_reg[tail_reg].last  <= final_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                tail_reg <= ~tail_reg;
            if (q_pop && q_valid)
                head_reg <= ~head_reg;
            if (push && !(q_pop && q_valid))
                cnt_reg <= cnt_reg + 2'd1;
            else if (!push && q_pop && q_valid)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lra_back.sv @@
`default_nettype none

module lra_back
    import lra_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire q_item_t              q_item,
    output logic                      q_pop,
    input  wire cfg_t                 cfg,
    input  wire logic [IDX_W-1:0]     last_idx,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ROW_OUT_W-1:0]      chosen_row,
    output logic [FILL_W-1:0]         widest_row,
    output logic                      set_done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    localparam int SUM_W = FILL_W + 2;

    logic [1:0]        state_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              cmp_vld_reg;
    logic [FILL_W-1:0] rd_data_reg;
    logic              rd_ok_reg;
    logic [FILL_W-1:0] best_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [FILL_W-1:0] widest_reg;

    logic [FILL_W-1:0] fill_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_ok_reg;

    logic [FILL_W-1:0] gap_fill;
    logic [FILL_W-1:0] cmp_val;
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] sat;
    logic [FILL_W-1:0] widest_new;
    logic              upd_fire;
    logic [IDX_W+ROW_OUT_W-1:0] pick_ext;

    logic              out_valid_reg;
    logic [ROW_OUT_W-1:0] chosen_reg;
    logic [FILL_W-1:0] widest_out_reg;
    logic              done_reg;

    assign gap_fill = FILL_W'(cfg.gap);
    assign cmp_val  = rd_ok_reg ? rd_data_reg : gap_fill;

    assign sum = SUM_W'(best_reg) + SUM_W'(q_item.width) + SUM_W'(cfg.gap);
    assign sat = (sum > SUM_W'(FILL_MAX)) ? FILL_MAX : sum[FILL_W-1:0];
    assign widest_new = (sat > widest_reg) ? sat : widest_reg;
    assign pick_ext = {{ROW_OUT_W{1'b0}}, pick_reg};

    // take the result only when the output slot is free or draining
    assign upd_fire = (state_reg == S_UPD) && (!out_valid_reg || out_ready);
    assign q_pop    = upd_fire;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= fill_mem[scan_idx_reg];
        if (upd_fire)
            fill_mem[pick_reg] <= sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            cmp_idx_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
            rd_ok_reg    <= 1'b0;
            best_reg     <= '0;
            pick_reg     <= '0;
            widest_reg   <= '0;
            row_ok_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg   <= row_ok_reg[scan_idx_reg];
            cmp_idx_reg <= scan_idx_reg;
            cmp_vld_reg <= (state_reg == S_SCAN);

            // keep the first minimum: strict compare favors the lower row
            if (cmp_vld_reg && ((cmp_idx_reg == '0) || (cmp_val < best_reg)))
            begin
                best_reg <= cmp_val;
                pick_reg <= cmp_idx_reg;
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    scan_idx_reg <= '0;
                    if (q_valid)
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_idx_reg == last_idx)
                        state_reg <= S_WAIT;
                    else
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                S_WAIT:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (upd_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        row_ok_reg[pick_reg] <= 1'b1;
                        widest_reg    <= widest_new;
                        if (q_item.last)
                        begin
                            row_ok_reg <= '0;
                            widest_reg <= gap_fill;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // reload every row on a row-count or gap-size register write
            if (cfg.reload)
            begin
                row_ok_reg <= '0;
                widest_reg <= gap_fill;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            chosen_reg     <= pick_ext[ROW_OUT_W-1:0];
            widest_out_reg <= widest_new;
            done_reg       <= q_item.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign chosen_row = chosen_reg;
    assign widest_row = widest_out_reg;
    assign set_done   = done_reg;

    a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> out_valid_reg)
        else $error("update did not raise a result");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> (pick_reg <= last_idx))
        else $error("picked row outside rows in use");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= last_idx))
        else $error("scan index past last row");

    a_reload_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.reload |=> (row_ok_reg == '0))
        else $error("rows not reloaded after register write");

    a_pop_only_upd: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && (state_reg == S_UPD)))
        else $error("queue popped outside update");

endmodule

`default_nettype wire
